// ===== rtl/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// Types, constants and helper functions shared by the line minimizer blocks.
// ----------------------------------------------------------------------------
package blm_pkg;

  localparam int VALUE_W = 32;
  localparam int WIDE_W  = 64;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = 97;
  localparam int QUOT_W  = 32;
  localparam int DIV_STEPS = 32;

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  localparam val_t  VAL_MAX  = 32'sh7fff_ffff;
  localparam val_t  VAL_MIN  = 32'sh8000_0000;
  localparam wide_t WIDE_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam wide_t WIDE_MIN = 64'sh8000_0000_0000_0000;

  // 0.381966 in Q0.32
  localparam logic [MUL_B_W-1:0] GOLDEN_Q32 = 33'd1640531478;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_LIMIT      = 2'd1,
    ST_NO_BRACKET = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_REL_TOL    = 2'd0,
    CFG_ABS_TOL    = 2'd1,
    CFG_ITER_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LOW,
    MP_HIGH
  } mul_ph_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LIMIT, S_REL, S_HALF, S_RHS, S_CONV,
    S_PA1, S_PA2, S_PA2W, S_PA3, S_PA4, S_PA4W, S_PA5, S_PA5W,
    S_PA6, S_PA6W, S_PA7, S_PA8, S_PA8W, S_PA9,
    S_AC1, S_AC1W, S_AC2, S_AC2W, S_AC3, S_AC3W,
    S_DIV, S_DIVW, S_UA, S_UB, S_UC, S_GOLD, S_GOLDW, S_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    logic command;
    val_t end_one;
    val_t end_two;
    val_t middle_point;
    val_t value_end_one;
    val_t value_end_two;
    val_t value_middle;
    val_t sample_value;
  } blm_in_t;

  typedef struct packed {
    logic    finished;
    val_t    query_point;
    status_t status;
    val_t    final_lower;
    val_t    final_upper;
    val_t    best_point;
    val_t    best_value;
  } blm_out_t;

  typedef struct packed {
    logic               start;
    logic [WIDE_W-1:0]  a_mag;
    logic [MUL_B_W-1:0] b_mag;
    logic               neg;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] dividend;
    logic [WIDE_W-1:0] divisor;
  } div_req_t;

  function automatic wide_t sext_v(val_t v);
    return {{(WIDE_W-VALUE_W){v[VALUE_W-1]}}, v};
  endfunction

  function automatic logic [WIDE_W-1:0] mag_w(wide_t v);
    return v[WIDE_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic val_t clamp_v(wide_t v);
    if (v > sext_v(VAL_MAX)) return VAL_MAX;
    else if (v < sext_v(VAL_MIN)) return VAL_MIN;
    else return v[VALUE_W-1:0];
  endfunction

endpackage

// ===== rtl/brent_line_minimizer.sv =====
// ----------------------------------------------------------------------------
// brent_line_minimizer
// Brent one-dimensional minimization controller: holds the bracket and the
// point history, and issues parabolic or golden-section query points.
// ----------------------------------------------------------------------------
// sequence: an unbracketed start goes straight to the result; otherwise the iteration
//   limit is checked, then convergence, then a golden-section step or a parabolic step
//   (nine multiplier passes plus a divider run); the result waits out any output stall
// throughput: one item at a time; input stalls until the result is loaded
// reset: synchronous active low; block idle, tolerances 7, iteration limit 75
module brent_line_minimizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  blm_pkg::blm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output blm_pkg::blm_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import blm_pkg::*;

  state_t   state_r, state_nxt;
  logic     searching_r, searching_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic [15:0] rel_tol_r, rel_tol_nxt;
  logic [30:0] abs_tol_r, abs_tol_nxt;
  logic [7:0]  iter_lim_r, iter_lim_nxt;
  logic [7:0]  iter_r, iter_nxt;

  val_t lo_r, lo_nxt, hi_r, hi_nxt, bx_r, bx_nxt, bfx_r, bfx_nxt;
  val_t sx_r, sx_nxt, sfx_r, sfx_nxt, tx_r, tx_nxt, tfx_r, tfx_nxt;
  val_t e_r, e_nxt, d_r, d_nxt, pend_r, pend_nxt, qry_r, qry_nxt;
  wide_t xm_r, xm_nxt, eps2_r, eps2_nxt, hw_r, hw_nxt, rhs_r, rhs_nxt;
  wide_t dxw_r, dxw_nxt, dxv_r, dxv_nxt, p_r, p_nxt, t_r, t_nxt;
  wide_t r_r, r_nxt, pa_r, pa_nxt, ee_r, ee_nxt, dd_r, dd_nxt, ua_r, ua_nxt;
  logic     fin_r, fin_nxt;
  status_t  status_r, status_nxt;
  blm_out_t out_r, out_nxt;

  alu_op_t alu_op;
  wide_t   alu_a, alu_b, alu_out;
  val_t    alu_clamp;
  mul_req_t mul_req;
  logic    mul_done;
  logic [PROD_W-1:0] mul_prod;
  wide_t   mul_res;
  div_req_t div_req;
  logic    div_done;
  logic [QUOT_W-1:0] div_q;

  wide_t x_w, eps_w, step_eps, dq, gp;
  logic  x_ge_xm;
  logic  swap, s_fail;
  val_t  s_lo, s_hi, s_flo, s_fhi;
  logic [WIDE_W-1:0] rel_part;

  blm_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_out)
  );

  blm_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mul_req),
    .done   (mul_done),
    .prod   (mul_prod),
    .result (mul_res)
  );

  blm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign alu_clamp = clamp_v(alu_out);
  assign x_w       = sext_v(bx_r);
  assign eps_w     = eps2_r >>> 1;
  assign x_ge_xm   = x_w >= xm_r;
  assign step_eps  = x_ge_xm ? -eps_w : eps_w;
  assign dq        = wide_t'({32'b0, div_q});
  assign gp        = wide_t'(mul_prod[95:32]);
  assign rel_part  = mul_prod[79:16];

  // start item: order the ends and check the bracket
  assign swap   = in_data.end_one > in_data.end_two;
  assign s_lo   = swap ? in_data.end_two : in_data.end_one;
  assign s_hi   = swap ? in_data.end_one : in_data.end_two;
  assign s_flo  = swap ? in_data.value_end_two : in_data.value_end_one;
  assign s_fhi  = swap ? in_data.value_end_one : in_data.value_end_two;
  assign s_fail = (s_flo < in_data.value_middle) || (s_fhi < in_data.value_middle) ||
                  (in_data.middle_point <= s_lo) || (in_data.middle_point >= s_hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      searching_r <= 1'b0;
      out_valid_r <= 1'b0;
      rel_tol_r   <= 16'd7;
      abs_tol_r   <= 31'd7;
      iter_lim_r  <= 8'd75;
    end else begin
      state_r     <= state_nxt;
      searching_r <= searching_nxt;
      out_valid_r <= out_valid_nxt;
      rel_tol_r   <= rel_tol_nxt;
      abs_tol_r   <= abs_tol_nxt;
      iter_lim_r  <= iter_lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    lo_r <= lo_nxt;   hi_r <= hi_nxt;   bx_r <= bx_nxt;   bfx_r <= bfx_nxt;
    sx_r <= sx_nxt;   sfx_r <= sfx_nxt; tx_r <= tx_nxt;   tfx_r <= tfx_nxt;
    e_r <= e_nxt;     d_r <= d_nxt;     pend_r <= pend_nxt; qry_r <= qry_nxt;
    xm_r <= xm_nxt;   eps2_r <= eps2_nxt; hw_r <= hw_nxt; rhs_r <= rhs_nxt;
    dxw_r <= dxw_nxt; dxv_r <= dxv_nxt; p_r <= p_nxt;     t_r <= t_nxt;
    r_r <= r_nxt;     pa_r <= pa_nxt;   ee_r <= ee_nxt;   dd_r <= dd_nxt;
    ua_r <= ua_nxt;   fin_r <= fin_nxt; status_r <= status_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    rel_tol_nxt  = rel_tol_r;
    abs_tol_nxt  = abs_tol_r;
    iter_lim_nxt = iter_lim_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REL_TOL:    rel_tol_nxt  = cfg_data[15:0];
        CFG_ABS_TOL:    abs_tol_nxt  = cfg_data[30:0];
        CFG_ITER_LIMIT: iter_lim_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    searching_nxt = searching_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    iter_nxt = iter_r;
    lo_nxt = lo_r;   hi_nxt = hi_r;   bx_nxt = bx_r;   bfx_nxt = bfx_r;
    sx_nxt = sx_r;   sfx_nxt = sfx_r; tx_nxt = tx_r;   tfx_nxt = tfx_r;
    e_nxt = e_r;     d_nxt = d_r;     pend_nxt = pend_r; qry_nxt = qry_r;
    xm_nxt = xm_r;   eps2_nxt = eps2_r; hw_nxt = hw_r; rhs_nxt = rhs_r;
    dxw_nxt = dxw_r; dxv_nxt = dxv_r; p_nxt = p_r;     t_nxt = t_r;
    r_nxt = r_r;     pa_nxt = pa_r;   ee_nxt = ee_r;   dd_nxt = dd_r;
    ua_nxt = ua_r;   fin_nxt = fin_r; status_nxt = status_r;
    alu_op  = ALU_ADD;
    alu_a   = '0;
    alu_b   = '0;
    mul_req = '0;
    div_req = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_START) begin
            lo_nxt  = s_lo;
            hi_nxt  = s_hi;
            bx_nxt  = in_data.middle_point;
            bfx_nxt = in_data.value_middle;
            sx_nxt  = in_data.middle_point;
            tx_nxt  = in_data.middle_point;
            sfx_nxt = in_data.value_middle;
            tfx_nxt = in_data.value_middle;
            e_nxt    = '0;
            d_nxt    = '0;
            pend_nxt = '0;
            iter_nxt = '0;
            searching_nxt = 1'b1;
            if (s_fail) begin
              fin_nxt    = 1'b1;
              status_nxt = ST_NO_BRACKET;
              qry_nxt    = '0;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_LIMIT;
            end
          end else if (searching_r) begin
            // fold the sample at the pending point into the triplet
            if (in_data.sample_value <= bfx_r) begin
              if (pend_r < bx_r) hi_nxt = bx_r;
              else lo_nxt = bx_r;
              tx_nxt  = sx_r;
              tfx_nxt = sfx_r;
              sx_nxt  = bx_r;
              sfx_nxt = bfx_r;
              bx_nxt  = pend_r;
              bfx_nxt = in_data.sample_value;
            end else begin
              if (pend_r < bx_r) lo_nxt = pend_r;
              else hi_nxt = pend_r;
              if (in_data.sample_value <= sfx_r || sx_r == bx_r) begin
                tx_nxt  = sx_r;
                tfx_nxt = sfx_r;
                sx_nxt  = pend_r;
                sfx_nxt = in_data.sample_value;
              end else if (in_data.sample_value <= tfx_r || tx_r == bx_r ||
                           tx_r == sx_r) begin
                tx_nxt  = pend_r;
                tfx_nxt = in_data.sample_value;
              end
            end
            state_nxt = S_LIMIT;
          end
        end
      end

      S_LIMIT: begin
        if (iter_r >= iter_lim_r) begin
          fin_nxt    = 1'b1;
          status_nxt = ST_LIMIT;
          qry_nxt    = '0;
          state_nxt  = S_EMIT;
        end else begin
          alu_a   = sext_v(lo_r);
          alu_b   = sext_v(hi_r);
          xm_nxt  = alu_out >>> 1;
          mul_req = '{start: 1'b1, a_mag: mag_w(x_w), b_mag: {17'b0, rel_tol_r},
                      neg: 1'b0};
          state_nxt = S_REL;
        end
      end

      S_REL: begin
        if (mul_done) begin
          eps2_nxt  = (rel_part > {33'b0, abs_tol_r}) ? wide_t'(rel_part)
                                                       : wide_t'({33'b0, abs_tol_r});
          state_nxt = S_HALF;
        end
      end

      S_HALF: begin
        alu_op    = ALU_SUB;
        alu_a     = sext_v(hi_r);
        alu_b     = sext_v(lo_r);
        hw_nxt    = alu_out >>> 1;
        state_nxt = S_RHS;
      end

      S_RHS: begin
        alu_op    = ALU_SUB;
        alu_a     = eps2_r;
        alu_b     = hw_r;
        rhs_nxt   = alu_out;
        state_nxt = S_CONV;
      end

      S_CONV: begin
        alu_op = ALU_SUB;
        alu_a  = x_w;
        alu_b  = xm_r;
        if (rhs_r > 0 && mag_w(alu_out) < $unsigned(rhs_r)) begin
          fin_nxt    = 1'b1;
          status_nxt = ST_CONVERGED;
          qry_nxt    = '0;
          state_nxt  = S_EMIT;
        end else if (mag_w(sext_v(e_r)) > $unsigned(eps_w)) begin
          state_nxt = S_PA1;
        end else begin
          state_nxt = S_GOLD;
        end
      end

      // parabola through best, second and third points
      S_PA1: begin
        alu_op    = ALU_SUB;
        alu_a     = x_w;
        alu_b     = sext_v(sx_r);
        dxw_nxt   = alu_out;
        state_nxt = S_PA2;
      end

      S_PA2: begin
        alu_op    = ALU_SUB;
        alu_a     = sext_v(bfx_r);
        alu_b     = sext_v(tfx_r);
        mul_req   = '{start: 1'b1, a_mag: mag_w(alu_out), b_mag: MUL_B_W'(mag_w(dxw_r)),
                      neg: alu_out[WIDE_W-1] ^ dxw_r[WIDE_W-1]};
        state_nxt = S_PA2W;
      end

      S_PA2W: begin
        if (mul_done) begin
          r_nxt     = mul_res;
          state_nxt = S_PA3;
        end
      end

      S_PA3: begin
        alu_op    = ALU_SUB;
        alu_a     = x_w;
        alu_b     = sext_v(tx_r);
        dxv_nxt   = alu_out;
        state_nxt = S_PA4;
      end

      S_PA4: begin
        alu_op    = ALU_SUB;
        alu_a     = sext_v(bfx_r);
        alu_b     = sext_v(sfx_r);
        mul_req   = '{start: 1'b1, a_mag: mag_w(alu_out), b_mag: MUL_B_W'(mag_w(dxv_r)),
                      neg: alu_out[WIDE_W-1] ^ dxv_r[WIDE_W-1]};
        state_nxt = S_PA4W;
      end

      S_PA4W: begin
        if (mul_done) begin
          t_nxt     = mul_res;
          state_nxt = S_PA5;
        end
      end

      S_PA5: begin
        mul_req   = '{start: 1'b1, a_mag: mag_w(t_r), b_mag: MUL_B_W'(mag_w(dxv_r)),
                      neg: t_r[WIDE_W-1] ^ dxv_r[WIDE_W-1]};
        state_nxt = S_PA5W;
      end

      S_PA5W: begin
        if (mul_done) begin
          pa_nxt    = mul_res;
          state_nxt = S_PA6;
        end
      end

      S_PA6: begin
        mul_req   = '{start: 1'b1, a_mag: mag_w(r_r), b_mag: MUL_B_W'(mag_w(dxw_r)),
                      neg: r_r[WIDE_W-1] ^ dxw_r[WIDE_W-1]};
        state_nxt = S_PA6W;
      end

      S_PA6W: begin
        if (mul_done) begin
          p_nxt     = mul_res;
          state_nxt = S_PA7;
        end
      end

      S_PA7: begin
        alu_op    = ALU_SUB;
        alu_a     = pa_r;
        alu_b     = p_r;
        p_nxt     = alu_out;
        state_nxt = S_PA8;
      end

      S_PA8: begin
        alu_op    = ALU_SUB;
        alu_a     = t_r;
        alu_b     = r_r;
        mul_req   = '{start: 1'b1, a_mag: mag_w(alu_out), b_mag: 33'd2,
                      neg: alu_out[WIDE_W-1]};
        state_nxt = S_PA8W;
      end

      S_PA8W: begin
        if (mul_done) begin
          t_nxt     = mul_res;
          state_nxt = S_PA9;
        end
      end

      S_PA9: begin
        if (t_r > 0) begin
          alu_op = ALU_SUB;
          alu_a  = '0;
          alu_b  = p_r;
          p_nxt  = alu_out;
        end
        t_nxt     = (t_r == WIDE_MIN) ? WIDE_MAX : wide_t'(mag_w(t_r));
        r_nxt     = sext_v(e_r);
        ee_nxt    = sext_v(d_r);
        state_nxt = S_AC1;
      end

      // acceptance tests for the parabolic step
      S_AC1: begin
        if (t_r > 0) begin
          mul_req   = '{start: 1'b1, a_mag: mag_w(t_r), b_mag: MUL_B_W'(mag_w(r_r)),
                        neg: r_r[WIDE_W-1]};
          state_nxt = S_AC1W;
        end else begin
          state_nxt = S_GOLD;
        end
      end

      S_AC1W: begin
        if (mul_done) begin
          state_nxt = (mag_w(p_r) < (mag_w(mul_res) >> 1)) ? S_AC2 : S_GOLD;
        end
      end

      S_AC2: begin
        alu_op    = ALU_SUB;
        alu_a     = sext_v(lo_r);
        alu_b     = x_w;
        mul_req   = '{start: 1'b1, a_mag: mag_w(t_r), b_mag: MUL_B_W'(mag_w(alu_out)),
                      neg: alu_out[WIDE_W-1]};
        state_nxt = S_AC2W;
      end

      S_AC2W: begin
        if (mul_done) state_nxt = (p_r > mul_res) ? S_AC3 : S_GOLD;
      end

      S_AC3: begin
        alu_op    = ALU_SUB;
        alu_a     = sext_v(hi_r);
        alu_b     = x_w;
        mul_req   = '{start: 1'b1, a_mag: mag_w(t_r), b_mag: MUL_B_W'(mag_w(alu_out)),
                      neg: alu_out[WIDE_W-1]};
        state_nxt = S_AC3W;
      end

      S_AC3W: begin
        if (mul_done) state_nxt = (p_r < mul_res) ? S_DIV : S_GOLD;
      end

      S_DIV: begin
        div_req   = '{start: 1'b1, dividend: mag_w(p_r), divisor: $unsigned(t_r)};
        state_nxt = S_DIVW;
      end

      S_DIVW: begin
        if (div_done) begin
          dd_nxt    = sext_v(clamp_v(p_r[WIDE_W-1] ? -dq : dq));
          state_nxt = S_UA;
        end
      end

      S_UA: begin
        alu_a     = x_w;
        alu_b     = dd_r;
        ua_nxt    = sext_v(alu_clamp);
        state_nxt = S_UB;
      end

      // keep the trial point away from the bracket ends
      S_UB: begin
        alu_op = ALU_SUB;
        alu_a  = ua_r;
        alu_b  = sext_v(lo_r);
        if (alu_out < eps2_r) begin
          dd_nxt    = sext_v(clamp_v(step_eps));
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UC;
        end
      end

      S_UC: begin
        alu_op = ALU_SUB;
        alu_a  = sext_v(hi_r);
        alu_b  = ua_r;
        if (alu_out < eps2_r) dd_nxt = sext_v(clamp_v(step_eps));
        state_nxt = S_FIN;
      end

      S_GOLD: begin
        alu_op    = ALU_SUB;
        alu_a     = x_ge_xm ? sext_v(lo_r) : sext_v(hi_r);
        alu_b     = x_w;
        ee_nxt    = sext_v(alu_clamp);
        mul_req   = '{start: 1'b1, a_mag: mag_w(sext_v(alu_clamp)), b_mag: GOLDEN_Q32,
                      neg: alu_clamp[VALUE_W-1]};
        state_nxt = S_GOLDW;
      end

      S_GOLDW: begin
        if (mul_done) begin
          dd_nxt    = sext_v(clamp_v(ee_r[WIDE_W-1] ? -gp : gp));
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (mag_w(dd_r) >= $unsigned(eps_w)) begin
          alu_a = x_w;
          alu_b = dd_r;
        end else begin
          alu_op = dd_r[WIDE_W-1] ? ALU_SUB : ALU_ADD;
          alu_a  = x_w;
          alu_b  = eps_w;
        end
        e_nxt      = clamp_v(ee_r);
        d_nxt      = clamp_v(dd_r);
        pend_nxt   = alu_clamp;
        qry_nxt    = alu_clamp;
        iter_nxt   = iter_r + 8'd1;
        fin_nxt    = 1'b0;
        status_nxt = ST_CONVERGED;
        state_nxt  = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = '{finished: fin_r, query_point: qry_r, status: status_r,
                      final_lower: lo_r, final_upper: hi_r, best_point: bx_r,
                      best_value: bfx_r};
          out_valid_nxt = 1'b1;
          if (fin_r) searching_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/blm_alu.sv =====
// ----------------------------------------------------------------------------
// blm_alu
// Shared 64-bit saturating add/subtract unit.
// ----------------------------------------------------------------------------
module blm_alu (
  input  blm_pkg::alu_op_t op,
  input  blm_pkg::wide_t   a,
  input  blm_pkg::wide_t   b,
  output blm_pkg::wide_t   y
);
  import blm_pkg::*;

  logic signed [WIDE_W:0] ext;

  always_comb begin
    unique case (op)
      ALU_ADD: ext = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
      ALU_SUB: ext = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
      default: ext = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    endcase
    if (ext[WIDE_W] != ext[WIDE_W-1]) begin
      y = ext[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end else begin
      y = ext[WIDE_W-1:0];
    end
  end

endmodule

// ===== rtl/blm_mul.sv =====
// ----------------------------------------------------------------------------
// blm_mul
// Shared magnitude multiplier, 64 x 33 bits in two 32 x 33 passes, with
// signed saturation of the product to 64 bits.
// ----------------------------------------------------------------------------
module blm_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  blm_pkg::mul_req_t           req,
  output logic                        done,
  output logic [blm_pkg::PROD_W-1:0]  prod,
  output blm_pkg::wide_t              result
);
  import blm_pkg::*;

  mul_ph_t             ph_r, ph_nxt;
  logic                done_r, done_nxt;
  logic [WIDE_W-1:0]   a_r, a_nxt;
  logic [MUL_B_W-1:0]  b_r, b_nxt;
  logic                neg_r, neg_nxt;
  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic [31:0]         half;
  logic [MUL_B_W+31:0] part;
  logic [PROD_W-1:0]   lim;
  logic [WIDE_W-1:0]   sat_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    half     = (ph_r == MP_HIGH) ? a_r[WIDE_W-1:32] : a_r[31:0];
    part     = half * b_r;
    unique case (ph_r)
      MP_IDLE: begin
        if (req.start) begin
          a_nxt   = req.a_mag;
          b_nxt   = req.b_mag;
          neg_nxt = req.neg;
          ph_nxt  = MP_LOW;
        end
      end
      MP_LOW: begin
        acc_nxt = {32'b0, part};
        ph_nxt  = MP_HIGH;
      end
      MP_HIGH: begin
        acc_nxt  = acc_r + {part, 32'b0};
        done_nxt = 1'b1;
        ph_nxt   = MP_IDLE;
      end
      default: ph_nxt = MP_IDLE;
    endcase
  end

  // limit is 2^63 for a negative product, 2^63-1 otherwise
  always_comb begin
    lim     = neg_r ? {33'b0, 64'h8000_0000_0000_0000} : {33'b0, 64'h7fff_ffff_ffff_ffff};
    sat_mag = (acc_r > lim) ? lim[WIDE_W-1:0] : acc_r[WIDE_W-1:0];
    result  = neg_r ? wide_t'(~sat_mag + 64'd1) : wide_t'(sat_mag);
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^32.
// ----------------------------------------------------------------------------
module blm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  blm_pkg::div_req_t           req,
  output logic                        done,
  output logic [blm_pkg::QUOT_W-1:0]  quotient
);
  import blm_pkg::*;

  localparam int DSR_W = WIDE_W + QUOT_W - 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic              ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    ge       = {{(DSR_W-WIDE_W){1'b0}}, rem_r} >= dsr_r;
    if (busy_r) begin
      if (ge) rem_nxt = rem_r - dsr_r[WIDE_W-1:0];
      q_nxt   = {q_r[QUOT_W-2:0], ge};
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.dividend;
      dsr_nxt  = {req.divisor[DSR_W-QUOT_W:0], {(QUOT_W-1){1'b0}}};
      q_nxt    = '0;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== tb/brent_line_minimizer_test.sv =====
// ----------------------------------------------------------------------------
// brent_line_minimizer_test
// Self-checking bench for the line minimizer: feeds bracket starts and
// sample values from a quadratic-like objective, predicts each result in
// fixed point and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module brent_line_minimizer_test;
  import blm_pkg::*;

  typedef logic signed [63:0] s64_t;
  localparam s64_t S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;
  localparam s64_t V_MAX = 64'sh0000_0000_7fff_ffff;
  localparam s64_t V_MIN = -64'sh0000_0000_8000_0000;
  localparam int CYCLE_LIMIT = 1500000;

  // ------------------------------------------------------------------
  // fixed-point helpers
  function automatic logic [63:0] mag64(s64_t v);
    return v < 0 ? 64'd0 - v : v;
  endfunction

  function automatic s64_t with_sign(bit neg, logic [63:0] m);
    if (neg) return m >= 64'h8000_0000_0000_0000 ? S64_MIN : -$signed(m);
    return m > 64'h7fff_ffff_ffff_ffff ? S64_MAX : $signed(m);
  endfunction

  function automatic s64_t sat_add(s64_t a, s64_t b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic s64_t sat_sub(s64_t a, s64_t b);
    if (b == S64_MIN) return a >= 0 ? S64_MAX : a + S64_MAX + 1;
    return sat_add(a, -b);
  endfunction

  function automatic s64_t sat_mul(s64_t a, s64_t b);
    logic [63:0] ua, ub, lim;
    bit neg;
    ua = mag64(a);
    ub = mag64(b);
    neg = (a < 0) != (b < 0);
    if (ua == 0 || ub == 0) return 0;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (ub > lim / ua) return with_sign(neg, lim);
    return with_sign(neg, ua * ub);
  endfunction

  function automatic s64_t half_down(s64_t v);
    return (v - (v & 1)) / 2;
  endfunction

  function automatic s64_t to_range(s64_t v);
    if (v > V_MAX) return V_MAX;
    if (v < V_MIN) return V_MIN;
    return v;
  endfunction

  // ------------------------------------------------------------------
  // scoreboard with its own copy of the search state
  class search_scoreboard;
    logic [15:0] rel_tol = 7;
    logic [30:0] abs_tol = 7;
    logic [7:0]  iter_max = 75;
    s64_t lo, hi, bx, bfx, wx, wfx, vx, vfx, e_old, d_old, pend;
    int   iters;
    bit   active;
    blm_out_t expected_q[$];
    int   errors;

    function void wipe();
      lo = 0; hi = 0; bx = 0; bfx = 0; wx = 0; wfx = 0; vx = 0; vfx = 0;
      e_old = 0; d_old = 0; pend = 0; iters = 0; active = 0;
    endfunction

    function void reg_write(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_REL_TOL:    rel_tol = v[15:0];
        CFG_ABS_TOL:    abs_tol = v[30:0];
        CFG_ITER_LIMIT: iter_max = v[7:0];
        default: ;
      endcase
    endfunction

    function void push(bit fin, s64_t q, status_t st);
      blm_out_t r;
      r.finished = fin;
      r.query_point = q[31:0];
      r.status = st;
      r.final_lower = lo[31:0];
      r.final_upper = hi[31:0];
      r.best_point = bx[31:0];
      r.best_value = bfx[31:0];
      expected_q.push_back(r);
      if (fin) active = 0;
    endfunction

    function void next_query();
      s64_t xm, eps2, eps, rhs, p, t, r, e, d, u, dxw, dxv, relp;
      logic [63:0] m, g;
      bit ok;
      p = 0; t = 0; r = 0;
      if (iters >= iter_max) begin
        push(1, 0, ST_LIMIT);
        return;
      end
      xm = half_down(sat_add(lo, hi));
      m = mag64(bx);
      relp = (m >> 16) * rel_tol + (((m & 64'hffff) * rel_tol) >> 16);
      eps2 = relp;
      if ($signed({33'd0, abs_tol}) > eps2) eps2 = abs_tol;
      eps = eps2 / 2;
      rhs = sat_sub(eps2, half_down(sat_sub(hi, lo)));
      if (rhs > 0 && mag64(sat_sub(bx, xm)) < rhs) begin
        push(1, 0, ST_CONVERGED);
        return;
      end
      e = e_old;
      d = d_old;
      if (mag64(e) > eps) begin
        dxw = sat_sub(bx, wx);
        dxv = sat_sub(bx, vx);
        r = sat_mul(dxw, sat_sub(bfx, vfx));
        t = sat_mul(dxv, sat_sub(bfx, wfx));
        p = sat_sub(sat_mul(dxv, t), sat_mul(dxw, r));
        t = sat_mul(2, sat_sub(t, r));
        if (t > 0) p = sat_sub(0, p);
        t = with_sign(0, mag64(t));
        r = e;
        e = d;
      end
      ok = t > 0 && mag64(p) < mag64(sat_mul(t, r)) / 2 &&
           p > sat_mul(t, sat_sub(lo, bx)) && p < sat_mul(t, sat_sub(hi, bx));
      if (ok) begin
        d = to_range(p / t);
        u = to_range(sat_add(bx, d));
        if (sat_sub(u, lo) < eps2 || sat_sub(hi, u) < eps2)
          d = to_range(bx >= xm ? -eps : eps);
      end else begin
        e = to_range(bx >= xm ? sat_sub(lo, bx) : sat_sub(hi, bx));
        m = mag64(e);
        g = (m >> 32) * 64'd1640531478 + (((m & 64'hffff_ffff) * 64'd1640531478) >> 32);
        d = to_range(with_sign(e < 0, g));
      end
      if (mag64(d) >= eps) u = sat_add(bx, d);
      else u = d >= 0 ? sat_add(bx, eps) : sat_sub(bx, eps);
      u = to_range(u);
      e_old = to_range(e);
      d_old = d;
      pend = u;
      iters++;
      push(0, u, ST_CONVERGED);
    endfunction

    function void note_input(blm_in_t it);
      s64_t a, b, x, fa, fb, fx, s, fu, u;
      if (it.command == CMD_START) begin
        a = it.end_one; b = it.end_two; x = it.middle_point;
        fa = it.value_end_one; fb = it.value_end_two; fx = it.value_middle;
        if (a > b) begin
          s = a; a = b; b = s;
          s = fa; fa = fb; fb = s;
        end
        lo = a; hi = b; bx = x; bfx = fx;
        wx = x; vx = x; wfx = fx; vfx = fx;
        e_old = 0; d_old = 0; pend = 0; iters = 0; active = 1;
        if (fa < fx || fb < fx || x <= a || x >= b) push(1, 0, ST_NO_BRACKET);
        else next_query();
        return;
      end
      if (!active) return;
      fu = it.sample_value;
      u = pend;
      if (fu <= bfx) begin
        if (u < bx) hi = bx; else lo = bx;
        vx = wx; vfx = wfx;
        wx = bx; wfx = bfx;
        bx = u; bfx = fu;
      end else begin
        if (u < bx) lo = u; else hi = u;
        if (fu <= wfx || wx == bx) begin
          vx = wx; vfx = wfx;
          wx = u; wfx = fu;
        end else if (fu <= vfx || vx == bx || vx == wx) begin
          vx = u; vfx = fu;
        end
      end
      next_query();
    endfunction

    function void check_result(blm_out_t got);
      blm_out_t x;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      x = expected_q.pop_front();
      if (got.finished !== x.finished) begin
        $error("finished exp %0d got %0d", x.finished, got.finished); errors++;
      end
      if (got.query_point !== x.query_point) begin
        $error("query_point exp %0d got %0d", x.query_point, got.query_point); errors++;
      end
      if (got.status !== x.status) begin
        $error("status exp %0d got %0d", x.status, got.status); errors++;
      end
      if (got.final_lower !== x.final_lower) begin
        $error("final_lower exp %0d got %0d", x.final_lower, got.final_lower); errors++;
      end
      if (got.final_upper !== x.final_upper) begin
        $error("final_upper exp %0d got %0d", x.final_upper, got.final_upper); errors++;
      end
      if (got.best_point !== x.best_point) begin
        $error("best_point exp %0d got %0d", x.best_point, got.best_point); errors++;
      end
      if (got.best_value !== x.best_value) begin
        $error("best_value exp %0d got %0d", x.best_value, got.best_value); errors++;
      end
    endfunction
  endclass

  // ------------------------------------------------------------------
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  blm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  blm_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  search_scoreboard sb;
  bit calm = 0;           // no idling near the end
  int cycles = 0;
  int sent = 0;           // accepted input transfers
  s64_t target_x;         // minimizer of the synthetic objective
  int   curve_shift;

  always #2 clk = ~clk;

  brent_line_minimizer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check each transfer, stall in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // valid stays up between back-to-back transfers and drops on an idle gap
  task automatic send_item(blm_in_t it);
    cfg_valid <= 0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.reg_write(idx, v);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // objective: shifted quadratic in units of 1/256, plus a constant offset
  function automatic s64_t objective(s64_t x);
    s64_t d;
    d = (x - target_x) >>> 8;
    return to_range(sat_add(sat_mul(d, d) >>> 8, curve_shift));
  endfunction

  function automatic blm_in_t start_item(s64_t a, s64_t b, s64_t m);
    blm_in_t it;
    it = '0;
    it.command = CMD_START;
    it.end_one = a[31:0]; it.end_two = b[31:0]; it.middle_point = m[31:0];
    it.value_end_one = val_t'(objective(a)); it.value_end_two = val_t'(objective(b));
    it.value_middle = val_t'(objective(m));
    it.sample_value = $urandom;
    return it;
  endfunction

  function automatic blm_in_t sample_item(s64_t u);
    blm_in_t it;
    it = '0;
    it.command = CMD_SAMPLE;
    it.end_one = $urandom; it.end_two = $urandom;
    it.sample_value = ($urandom_range(0, 15) == 0) ? val_t'($urandom)
                                                   : val_t'(objective(u));
    return it;
  endfunction

  // one search: start, then answer queries until done or a cutoff
  task automatic run_search(int cutoff, int span);
    s64_t a, b, m;
    blm_in_t it;
    int n;
    target_x = $signed($urandom) >>> $urandom_range(1, 12);
    curve_shift = $signed($urandom) >>> $urandom_range(4, 20);
    a = target_x - $urandom_range(256, span);
    b = target_x + $urandom_range(256, span);
    m = target_x + $signed($urandom_range(0, 200)) - 100;
    a = to_range(a); b = to_range(b);
    if ($urandom_range(0, 1)) begin
      it = start_item(b, a, m);
    end else begin
      it = start_item(a, b, m);
    end
    send_item(it);
    for (n = 0; n < cutoff && sb.active; n++) send_item(sample_item(sb.pend));
  endtask

  int i;
  int phase_end;
  blm_in_t it;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: idle sample, unbracketed starts, extremes, limit of zero
    it = '0;
    it.command = CMD_SAMPLE;
    it.sample_value = 32'sh7fff_ffff;
    send_item(it);
    target_x = 0; curve_shift = 0;
    send_item(start_item(-1000, 1000, 2000));
    send_item(start_item(1000, -1000, 0));
    send_item(start_item(V_MIN, V_MAX, 0));
    it = start_item(-4096, 4096, 0);
    it.value_end_one = 32'sh8000_0000;
    send_item(it);
    it = start_item(-4096, 4096, 0);
    it.value_middle = 32'sh8000_0000;
    it.value_end_one = 32'sh7fff_ffff; it.value_end_two = 32'sh7fff_ffff;
    send_item(it);
    for (i = 0; i < 6 && sb.active; i++) send_item(sample_item(sb.pend));
    send_item(start_item(-65536, 65536, 100));
    send_item(start_item(-65536, 65536, -100));  // restart while searching
    for (i = 0; i < 8 && sb.active; i++) begin
      it = sample_item(sb.pend);
      it.sample_value = (i == 3) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      send_item(it);
    end
    settle();
    write_reg(CFG_ITER_LIMIT, 0);
    send_item(start_item(-65536, 65536, 0));
    settle();
    write_reg(CFG_ITER_LIMIT, 1);
    write_reg(CFG_REL_TOL, 16'hffff);
    write_reg(CFG_ABS_TOL, 31'h7fff_ffff);
    send_item(start_item(-65536, 65536, 0));
    settle();
    write_reg(CFG_REL_TOL, 0);
    write_reg(CFG_ABS_TOL, 0);
    write_reg(CFG_ITER_LIMIT, 255);
    run_search(300, 1 << 20);
    settle();

    // random phases with different settings
    for (i = 0; i < 6; i++) begin
      write_reg(CFG_REL_TOL, (i == 5) ? 16'hffff : $urandom_range(0, 400));
      write_reg(CFG_ABS_TOL, (i == 4) ? 32'h7fff_ffff : $urandom_range(0, 64));
      write_reg(CFG_ITER_LIMIT, (i == 3) ? 1 : $urandom_range(5, 80));
      if (i == 5) calm = 1;
      phase_end = sent + 165;
      while (sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          it = '0;
          it.command = $urandom_range(0, 1);
          {it.end_one, it.end_two, it.middle_point} = {$urandom, $urandom, $urandom};
          {it.value_end_one, it.value_end_two} = {$urandom, $urandom};
          {it.value_middle, it.sample_value} = {$urandom, $urandom};
          send_item(it);
        end else begin
          run_search($urandom_range(3, 40), $urandom_range(0, 3) == 0 ? 1 << 28 : 1 << 18);
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
